FILE: rtl/core/trg_pkg.sv
`default_nettype none

package trg_pkg;

    localparam int NODE_W      = 10;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 2;
    localparam int MAX_RESULTS = 33;
    localparam int DIV_STEPS   = NODE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [1:0] {
        KIND_ROUTE = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_BAD   = 2'd2
    } trg_kind_t;

endpackage

`default_nettype wire

FILE: rtl/core/trg_fifo.sv
`default_nettype none

module trg_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/trg_front.sv
`default_nettype none

module trg_front
    import trg_pkg::*;
#(
    parameter int MAX_SIDE = 32,
    localparam int SW      = $clog2(MAX_SIDE + 1),
    localparam int CW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int ENTRY_W = 2 + 4 * CW + 2 * SW
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [NODE_W-1:0] req_start,
    input  wire logic [NODE_W-1:0] req_end,
    input  wire logic [SW-1:0]     side_cols,
    input  wire logic [SW-1:0]     side_rows,
    output logic                   q_push,
    input  wire logic              q_full,
    output logic [ENTRY_W-1:0]     q_data
);

    localparam int TW   = 2 * SW;
    localparam int CMPW = (TW > NODE_W) ? TW : NODE_W;
    localparam int STW  = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic [STW-1:0]    step_reg, step_next;
    trg_kind_t         kind_reg;
    logic [NODE_W-1:0] ds_s_reg, ds_e_reg;
    logic [SW-1:0]     rs_s_reg, rs_e_reg;
    logic [SW-1:0]     cols_reg, rows_reg;

    logic [TW-1:0]     total;
    logic              node_bad;
    logic [SW:0]       trial_s, trial_e;
    logic              ge_s, ge_e;
    logic              accept;

    assign total     = TW'(side_cols) * TW'(side_rows);
    assign node_bad  = (CMPW'(req_start) >= CMPW'(total)) || (CMPW'(req_end) >= CMPW'(total));
    assign req_ready = (state_reg == F_IDLE);
    assign accept    = req_valid && req_ready;

    assign trial_s = {rs_s_reg, ds_s_reg[NODE_W-1]};
    assign trial_e = {rs_e_reg, ds_e_reg[NODE_W-1]};
    assign ge_s    = (trial_s >= {1'b0, cols_reg});
    assign ge_e    = (trial_e >= {1'b0, cols_reg});

    assign q_push = (state_reg == F_PUSH);
    assign q_data = {rows_reg, cols_reg,
                     CW'(ds_e_reg), CW'(rs_e_reg),
                     CW'(ds_s_reg), CW'(rs_s_reg),
                     kind_reg};

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE: begin
                step_next = '0;
                if (accept) begin
                    state_next = (node_bad || req_start == req_end) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                step_next = step_reg + STW'(1);
                if (step_reg == STW'(DIV_STEPS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cols_reg <= side_cols;
            rows_reg <= side_rows;
            ds_s_reg <= req_start;
            ds_e_reg <= req_end;
            rs_s_reg <= '0;
            rs_e_reg <= '0;
            if (node_bad) begin
                kind_reg <= KIND_BAD;
            end else if (req_start == req_end) begin
                kind_reg <= KIND_EMPTY;
            end else begin
                kind_reg <= KIND_ROUTE;
            end
        end else if (state_reg == F_DIV) begin
            ds_s_reg <= {ds_s_reg[NODE_W-2:0], ge_s};
            ds_e_reg <= {ds_e_reg[NODE_W-2:0], ge_e};
            rs_s_reg <= ge_s ? SW'(trial_s - {1'b0, cols_reg}) : SW'(trial_s);
            rs_e_reg <= ge_e ? SW'(trial_e - {1'b0, cols_reg}) : SW'(trial_e);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/trg_back.sv
`default_nettype none

module trg_back
    import trg_pkg::*;
#(
    parameter int MAX_SIDE = 32,
    localparam int SW      = $clog2(MAX_SIDE + 1),
    localparam int CW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int ENTRY_W = 2 + 4 * CW + 2 * SW
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire logic [ENTRY_W-1:0] q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [NODE_W-1:0]       out_hop_node,
    output logic [1:0]              out_next_dir,
    output logic                    out_last_hop,
    output logic                    out_route_empty,
    output logic                    out_bad_request
);

    localparam int MW  = SW + 2;
    localparam int KW  = $clog2(MAX_RESULTS);
    localparam int NPW = CW + SW + 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_WALK = 2'b10
    } back_state_t;

    function automatic logic signed [MW-1:0] ring_off(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b,
        input logic [SW-1:0] n
    );
        logic signed [MW-1:0] m;
        logic signed [MW-1:0] am;
        logic signed [MW-1:0] half;
        logic signed [MW-1:0] nn;
        m    = signed'(MW'(b)) - signed'(MW'(a));
        half = signed'(MW'(n >> 1));
        nn   = signed'(MW'(n));
        am   = (m < 0) ? -m : m;
        if (am > half) begin
            m = (m > 0) ? m - nn : m + nn;
        end
        return m;
    endfunction

    back_state_t       state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              valid_reg, valid_next;
    trg_kind_t         kind_reg;
    logic [CW-1:0]     cc_reg, cr_reg, dc_reg, dr_reg;
    logic [SW-1:0]     cols_reg, rows_reg;
    logic [NODE_W-1:0] hop_reg;
    logic [1:0]        dir_reg;
    logic              last_reg, empty_reg, bad_reg;

    logic              out_free, emit, at_dest, at_cap, go_x, route_done;
    logic signed [MW-1:0] mx, my, ax, ay;
    logic [NPW-1:0]    prod;
    logic [NODE_W-1:0] node;
    logic [1:0]        dir;
    logic [CW-1:0]     col_max, row_max;
    logic [CW-1:0]     cc_next, cr_next;

    assign out_free   = !valid_reg || out_ready;
    assign emit       = (state_reg == B_WALK) && out_free;
    assign q_pop      = (state_reg == B_IDLE) && !q_empty;
    assign at_dest    = (cc_reg == dc_reg) && (cr_reg == dr_reg);
    assign at_cap     = (k_reg == KW'(MAX_RESULTS - 1));
    assign route_done = at_dest || at_cap || (kind_reg != KIND_ROUTE);

    assign mx   = ring_off(cc_reg, dc_reg, cols_reg);
    assign my   = ring_off(cr_reg, dr_reg, rows_reg);
    assign ax   = (mx < 0) ? -mx : mx;
    assign ay   = (my < 0) ? -my : my;
    assign go_x = (ax > ay);

    assign prod = NPW'(cr_reg) * NPW'(cols_reg);
    assign node = NODE_W'(prod + NPW'(cc_reg));

    assign col_max = CW'(cols_reg - SW'(1));
    assign row_max = CW'(rows_reg - SW'(1));

    always_comb begin
        dir     = DIR_DOWN;
        cc_next = cc_reg;
        cr_next = cr_reg;
        if (go_x) begin
            if (mx < 0) begin
                dir     = DIR_LEFT;
                cc_next = (cc_reg == '0) ? col_max : cc_reg - CW'(1);
            end else begin
                dir     = DIR_RIGHT;
                cc_next = (cc_reg == col_max) ? '0 : cc_reg + CW'(1);
            end
        end else begin
            if (my < 0) begin
                dir     = DIR_UP;
                cr_next = (cr_reg == '0) ? row_max : cr_reg - CW'(1);
            end else begin
                dir     = DIR_DOWN;
                cr_next = (cr_reg == row_max) ? '0 : cr_reg + CW'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE: begin
                k_next = '0;
                if (q_pop) begin
                    state_next = B_WALK;
                end
            end
            B_WALK: begin
                if (emit) begin
                    valid_next = 1'b1;
                    k_next     = k_reg + KW'(1);
                    if (route_done) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg <= trg_kind_t'(q_data[1:0]);
            cc_reg   <= q_data[2 +: CW];
            cr_reg   <= q_data[2 + CW +: CW];
            dc_reg   <= q_data[2 + 2 * CW +: CW];
            dr_reg   <= q_data[2 + 3 * CW +: CW];
            cols_reg <= q_data[2 + 4 * CW +: SW];
            rows_reg <= q_data[2 + 4 * CW + SW +: SW];
        end else if (emit && !route_done) begin
            cc_reg <= cc_next;
            cr_reg <= cr_next;
        end
        if (emit) begin
            case (kind_reg)
                KIND_ROUTE: begin
                    hop_reg   <= node;
                    dir_reg   <= route_done ? DIR_UP : dir;
                    last_reg  <= route_done;
                    empty_reg <= 1'b0;
                    bad_reg   <= 1'b0;
                end
                KIND_EMPTY: begin
                    hop_reg   <= '0;
                    dir_reg   <= DIR_UP;
                    last_reg  <= 1'b1;
                    empty_reg <= 1'b1;
                    bad_reg   <= 1'b0;
                end
                default: begin
                    hop_reg   <= '0;
                    dir_reg   <= DIR_UP;
                    last_reg  <= 1'b1;
                    empty_reg <= 1'b0;
                    bad_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid       = valid_reg;
    assign out_hop_node    = hop_reg;
    assign out_next_dir    = dir_reg;
    assign out_last_hop    = last_reg;
    assign out_route_empty = empty_reg;
    assign out_bad_request = bad_reg;

endmodule

`default_nettype wire

FILE: rtl/core/torus_route_generator_top.sv
// Minimal-path route generator for a grid_rows by grid_cols torus, nodes numbered
// row * cols + column. Each input beat carries a start and an end node; the block
// answers with every node of the path, start through end, one output beat each,
// tlast on the final one, and a direction toward the next hop on all others. A
// request with a node outside the grid gives one beat flagged bad_request, and a
// start equal to the end gives one beat flagged route_empty. The front end classifies
// a request as it accepts it; a routable one then passes through a radix-2 divider
// that splits both node numbers into row and column, and the command then enters a
// two-entry command queue. The front end takes no new request until its command is
// pushed, and waits while the queue is full. The back end pops a command while idle
// and then delivers one beat per clock while m_tready is high, up to the 33-beat
// cap, and pops the next command only after the final beat of a route.
`default_nettype none

module torus_route_generator_top
    import trg_pkg::*;
#(
    parameter int MAX_SIDE = 32,
    localparam int SW      = $clog2(MAX_SIDE + 1),
    localparam int CW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int ENTRY_W = 2 + 4 * CW + 2 * SW
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0 up: start_node[9:0], end_node[19:10], zero fill.
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0 up: hop_node[9:0], next_dir[11:10], zero fill.
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast,
    // Fields from bit 0 up: route_empty[0], bad_request[1].
    output logic [OUT_USER_W-1:0]      m_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    function automatic logic [SW-1:0] eff_side(input logic [CFG_W-1:0] v);
        logic [7:0] w;
        w = 8'(v);
        if (w == 8'd0) begin
            return SW'(1);
        end
        if (w > 8'(MAX_SIDE)) begin
            return SW'(MAX_SIDE);
        end
        return SW'(w);
    endfunction

    logic [CFG_W-1:0]   grid_cols_reg, grid_rows_reg;
    logic [SW-1:0]      side_cols, side_rows;
    logic               q_push, q_full, q_pop, q_empty;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;
    logic [NODE_W-1:0]  hop_node;
    logic [1:0]         next_dir;
    logic               route_empty, bad_request;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= CFG_W'(4);
            grid_rows_reg <= CFG_W'(4);
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_GRID_COLS) begin
                grid_cols_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_GRID_ROWS) begin
                grid_rows_reg <= cfg_wdata;
            end
        end
    end

    assign side_cols = eff_side(grid_cols_reg);
    assign side_rows = eff_side(grid_rows_reg);

    trg_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_start (s_tdata[NODE_W-1:0]),
        .req_end   (s_tdata[2*NODE_W-1:NODE_W]),
        .side_cols (side_cols),
        .side_rows (side_rows),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_data    (q_wdata)
    );

    trg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    trg_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_hop_node    (hop_node),
        .out_next_dir    (next_dir),
        .out_last_hop    (m_tlast),
        .out_route_empty (route_empty),
        .out_bad_request (bad_request)
    );

    assign m_tdata = {(OUT_DATA_W - NODE_W - 2)'(0), next_dir, hop_node};
    assign m_tuser = {bad_request, route_empty};

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(route_empty && bad_request))
        else $error("route_empty and bad_request set on the same beat");

    a_flag_beat_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (route_empty || bad_request) |->
            m_tlast && hop_node == '0 && next_dir == DIR_UP)
        else $error("flagged beat is not a lone final beat with zero payload");

    a_last_dir_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> next_dir == DIR_UP)
        else $error("final beat carries a direction");

    a_pop_into_empty_back: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !q_pop)
        else $error("back end popped two commands in a row");

endmodule

`default_nettype wire

FILE: tb/sv/torus_route_generator_top_tb.sv
`timescale 1ns / 100ps

module torus_route_generator_top_tb;
    import trg_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEMS_PER_GRID = 11;

    typedef struct packed {
        logic [NODE_W-1:0] hop_node;
        logic [1:0]        next_dir;
        logic              last_hop;
        logic              route_empty;
        logic              bad_request;
    } hop_beat_t;

    typedef struct {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        trg_kind_t         kind;
    } route_req_t;

    typedef struct {
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
    } grid_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_COLS;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    logic [CFG_W-1:0] grid_cols = 6'd4;
    logic [CFG_W-1:0] grid_rows = 6'd4;
    hop_beat_t        pending_hops[$];
    hop_beat_t        seen_hop;
    hop_beat_t        want_hop;
    int               errors       = 0;
    int               stall_cycles = 0;
    int               rx_gap       = 0;
    int               hold_asks    = 0;
    int               holds_served = 0;
    bit               calm         = 1'b0;

    // The directed rows run on the 4 by 4 grid that reset selects.
    route_req_t directed_reqs [22] = '{
        '{10'd0,    10'd0,    KIND_EMPTY},
        '{10'd15,   10'd15,   KIND_EMPTY},
        '{10'd16,   10'd0,    KIND_BAD},
        '{10'd0,    10'd16,   KIND_BAD},
        '{10'd1023, 10'd5,    KIND_BAD},
        '{10'd3,    10'd1023, KIND_BAD},
        '{10'd1023, 10'd1023, KIND_BAD},
        '{10'd0,    10'd15,   KIND_ROUTE},
        '{10'd15,   10'd0,    KIND_ROUTE},
        '{10'd0,    10'd1,    KIND_ROUTE},
        '{10'd1,    10'd0,    KIND_ROUTE},
        '{10'd0,    10'd4,    KIND_ROUTE},
        '{10'd4,    10'd0,    KIND_ROUTE},
        '{10'd0,    10'd2,    KIND_ROUTE},
        '{10'd2,    10'd0,    KIND_ROUTE},
        '{10'd0,    10'd8,    KIND_ROUTE},
        '{10'd8,    10'd0,    KIND_ROUTE},
        '{10'd0,    10'd10,   KIND_ROUTE},
        '{10'd5,    10'd3,    KIND_ROUTE},
        '{10'd12,   10'd3,    KIND_ROUTE},
        '{10'd0,    10'd3,    KIND_ROUTE},
        '{10'd0,    10'd12,   KIND_ROUTE}
    };

    grid_t grid_plan [9] = '{
        '{6'd32, 6'd32},
        '{6'd0,  6'd63},
        '{6'd63, 6'd0},
        '{6'd33, 6'd5},
        '{6'd1,  6'd1},
        '{6'd7,  6'd3},
        '{6'd2,  6'd32},
        '{6'd17, 6'd33},
        '{6'd5,  6'd6}
    };

    always #HALF_PERIOD aclk = ~aclk;

    torus_route_generator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic int side_of(logic [CFG_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        return (v > 32) ? 32 : int'(v);
    endfunction

    // Signed offset from a to b the shorter way round a ring of n positions.
    function automatic int wrap_offset(int a, int b, int n);
        int m;
        int half;
        m    = b - a;
        half = n / 2;
        if ((m < 0 ? -m : m) > half) begin
            m = (m > 0) ? m - n : m + n;
        end
        return m;
    endfunction

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void queue_hop(hop_beat_t hop);
        pending_hops.insert(pending_hops.size(), hop);
    endfunction

    function automatic void plan_route(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
        int        cols;
        int        rows;
        int        cc;
        int        cr;
        int        dc;
        int        dr;
        int        dx;
        int        dy;
        hop_beat_t hop;
        cols         = side_of(grid_cols);
        rows         = side_of(grid_rows);
        hop          = '0;
        hop.last_hop = 1'b1;
        if (int'(src) >= cols * rows || int'(dst) >= cols * rows) begin
            hop.bad_request = 1'b1;
            queue_hop(hop);
            return;
        end
        if (src == dst) begin
            hop.route_empty = 1'b1;
            queue_hop(hop);
            return;
        end
        cc = int'(src) % cols;
        cr = int'(src) / cols;
        dc = int'(dst) % cols;
        dr = int'(dst) / cols;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            hop          = '0;
            hop.hop_node = NODE_W'(cr * cols + cc);
            if ((cc == dc && cr == dr) || k == MAX_RESULTS - 1) begin
                hop.last_hop = 1'b1;
                queue_hop(hop);
                break;
            end
            dx = wrap_offset(cc, dc, cols);
            dy = wrap_offset(cr, dr, rows);
            if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
                hop.next_dir = (dx < 0) ? DIR_LEFT : DIR_RIGHT;
                cc           = (cc + ((dx < 0) ? cols - 1 : 1)) % cols;
            end else begin
                hop.next_dir = (dy < 0) ? DIR_UP : DIR_DOWN;
                cr           = (cr + ((dy < 0) ? rows - 1 : 1)) % rows;
            end
            queue_hop(hop);
        end
    endfunction

    task automatic send_request(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                                trg_kind_t kind);
        int gap;
        gap = (!calm && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 2 * NODE_W){1'b0}}, dst, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (kind)
            KIND_EMPTY: queue_hop('{hop_node: '0, next_dir: DIR_UP,
                last_hop: 1'b1, route_empty: 1'b1, bad_request: 1'b0});
            KIND_BAD: queue_hop('{hop_node: '0, next_dir: DIR_UP,
                last_hop: 1'b1, route_empty: 1'b0, bad_request: 1'b1});
            default: plan_route(src, dst);
        endcase
    endtask

    task automatic drain_routes();
        s_tvalid <= 1'b0;
        while (pending_hops.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (holds_served != hold_asks) begin
            holds_served <= holds_served + 1;
            rx_gap       <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rx_gap   <= gap_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_hop = '{hop_node: m_tdata[NODE_W-1:0], next_dir: m_tdata[NODE_W+1:NODE_W],
                         last_hop: m_tlast, route_empty: m_tuser[0], bad_request: m_tuser[1]};
            if (pending_hops.size() == 0) begin
                errors++;
                $display("%0t: expected no beat, got %p", $time, seen_hop);
            end else begin
                want_hop = pending_hops.pop_front();
                if (seen_hop !== want_hop) begin
                    errors++;
                    $display("%0t: expected %p, got %p", $time, want_hop, seen_hop);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_hops.size() == 0 && !s_tvalid)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int                total;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_reqs[i]) begin
            send_request(directed_reqs[i].src, directed_reqs[i].dst, directed_reqs[i].kind);
        end
        drain_routes();
        foreach (grid_plan[p]) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_GRID_COLS;
            cfg_wdata <= grid_plan[p].cols;
            @(posedge aclk);
            cfg_index <= CFG_GRID_ROWS;
            cfg_wdata <= grid_plan[p].rows;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            grid_cols = grid_plan[p].cols;
            grid_rows = grid_plan[p].rows;
            calm      <= (p % 3 == 2);
            if (p == 0) begin
                hold_asks <= hold_asks + 1;
            end
            total = side_of(grid_cols) * side_of(grid_rows);
            repeat (ITEMS_PER_GRID) begin
                src_node = NODE_W'($urandom_range(0, total - 1));
                dst_node = NODE_W'($urandom_range(0, total - 1));
                case ($urandom_range(0, 9))
                    0: begin
                        src_node = NODE_W'($urandom);
                        dst_node = NODE_W'($urandom);
                    end
                    1: dst_node = src_node;
                    2: begin
                        if (total < 1024) begin
                            dst_node = NODE_W'($urandom_range(total, 1023));
                        end
                        if ($urandom_range(0, 1) == 1) begin
                            {src_node, dst_node} = {dst_node, src_node};
                        end
                    end
                    default: ;
                endcase
                send_request(src_node, dst_node, KIND_ROUTE);
            end
            drain_routes();
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/trg_pkg.sv
rtl/core/trg_fifo.sv
rtl/core/trg_front.sv
rtl/core/trg_back.sv
rtl/core/torus_route_generator_top.sv
tb/sv/torus_route_generator_top_tb.sv
